@@ hdl/stsq_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the step table sequencer
package stsq_pkg;

    typedef enum logic [3:0] {
        CMD_LOAD     = 4'd0,
        CMD_CLEAR    = 4'd1,
        CMD_START    = 4'd2,
        CMD_PAUSE    = 4'd3,
        CMD_RESUME   = 4'd4,
        CMD_ABORT    = 4'd5,
        CMD_RESET    = 4'd6,
        CMD_TICK     = 4'd7,
        CMD_COMPLETE = 4'd8
    } cmd_t;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_RUNNING = 5'b00010,
        MODE_PAUSED  = 5'b00100,
        MODE_DONE    = 5'b01000,
        MODE_FAULT   = 5'b10000
    } mode_t;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_TIMEOUT = 2'd1,
        CAUSE_FAILED  = 2'd2,
        CAUSE_ABORT   = 2'd3
    } cause_t;

    localparam logic [2:0] RS_IDLE    = 3'd0;
    localparam logic [2:0] RS_RUNNING = 3'd1;
    localparam logic [2:0] RS_PAUSED  = 3'd2;
    localparam logic [2:0] RS_DONE    = 3'd3;
    localparam logic [2:0] RS_FAULT   = 3'd4;

    typedef struct packed {
        logic [23:0] limit_ms;
        logic [23:0] nominal_ms;
    } step_row_t;

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] code;
        case (m)
            MODE_IDLE:    code = RS_IDLE;
            MODE_RUNNING: code = RS_RUNNING;
            MODE_PAUSED:  code = RS_PAUSED;
            MODE_DONE:    code = RS_DONE;
            MODE_FAULT:   code = RS_FAULT;
            default:      code = RS_IDLE;
        endcase
        return code;
    endfunction

endpackage

@@ hdl/stsq_ram.sv @@
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read
module stsq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents when both ports hit the same entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/step_table_sequencer_with_timeout.sv @@
`timescale 1ns / 1ps
// step table sequencer with per-step timeout
// pipeline: update stage, then output register; throughput: one command per cycle
// while in_stall is low; the step table ram is read every cycle at the step index of the
// next state, so the current limit and nominal are always at hand
// reset: asynchronous, clears mode, counters, times and pipeline valids at once;
// table contents are undefined until loaded and need no clearing pass
module step_table_sequencer_with_timeout
    import stsq_pkg::*;
#(
    parameter int MAX_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  cmd,
    input  logic [15:0] tick_ms,
    input  logic        step_ok,
    input  logic [23:0] nominal_ms,
    input  logic [23:0] limit_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  run_state,
    output logic [4:0]  step_number,
    output logic [31:0] step_time,
    output logic [31:0] run_time,
    output logic [1:0]  fault_cause,
    output logic        accepted,
    output logic        rejected,
    output logic [4:0]  finished_count,
    output logic [4:0]  loaded_count,
    output logic [23:0] current_nominal,
    output logic [31:0] record_time,
    output logic        record_valid
);

    localparam int CNT_W  = $clog2(MAX_STEPS + 1);
    localparam int ADDR_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int ROW_W  = $bits(step_row_t);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STEPS);

    // sequencer state
    mode_t            mode_reg, mode_next;
    cause_t           cause_reg, cause_next;
    logic [CNT_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] records_reg, records_next;
    logic [31:0]      step_t_reg, step_t_next;
    logic [31:0]      run_t_reg, run_t_next;

    // table access
    logic              tbl_we;
    logic [ADDR_W-1:0] tbl_waddr;
    logic [ADDR_W-1:0] tbl_raddr;
    step_row_t         tbl_wrow;
    logic [ROW_W-1:0]  tbl_rdata;
    logic              fwd_hit_reg, fwd_hit_next;
    step_row_t         fwd_row_reg;
    step_row_t         cur_row;

    // update stage and output register
    logic        take;
    logic        s1_adv;
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_acc_reg, s1_rej_reg, s1_recv_reg;
    logic [31:0] s1_rect_reg;
    logic        acc_c, rej_c, recv_c;
    logic [31:0] rect_c;
    logic        out_valid_reg, out_valid_next;

    logic [32:0] step_sum;
    logic [32:0] run_sum;
    logic [31:0] step_sat;
    logic [31:0] run_sat;
    logic        past_end;
    logic [CNT_W-1:0] cur_inc;

    logic [2:0]  o_state_reg;
    logic [4:0]  o_step_reg;
    logic [31:0] o_step_t_reg;
    logic [31:0] o_run_t_reg;
    logic [1:0]  o_cause_reg;
    logic        o_acc_reg;
    logic        o_rej_reg;
    logic [4:0]  o_fin_reg;
    logic [4:0]  o_load_reg;
    logic [23:0] o_nom_reg;
    logic [31:0] o_rect_reg;
    logic        o_recv_reg;

    stsq_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_STEPS)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wrow),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // row of the current step, with a load to that same entry forwarded
    assign cur_row  = fwd_hit_reg ? fwd_row_reg : step_row_t'(tbl_rdata);
    assign past_end = (cur_reg >= count_reg);
    assign cur_inc  = cur_reg + CNT_W'(1);

    assign step_sum = {1'b0, step_t_reg} + 33'(tick_ms);
    assign run_sum  = {1'b0, run_t_reg} + 33'(tick_ms);
    assign step_sat = step_sum[32] ? 32'hFFFF_FFFF : step_sum[31:0];
    assign run_sat  = run_sum[32] ? 32'hFFFF_FFFF : run_sum[31:0];

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign take     = in_valid && !in_stall;

    assign s1_valid_next  = take || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && out_stall);

    assign tbl_waddr    = count_reg[ADDR_W-1:0];
    assign tbl_wrow     = '{limit_ms: limit_ms, nominal_ms: nominal_ms};
    assign tbl_raddr    = cur_next[ADDR_W-1:0];
    assign fwd_hit_next = tbl_we && (tbl_waddr == tbl_raddr);

    always_comb
    begin
        mode_next    = mode_reg;
        cause_next   = cause_reg;
        cur_next     = cur_reg;
        count_next   = count_reg;
        records_next = records_reg;
        step_t_next  = step_t_reg;
        run_t_next   = run_t_reg;
        tbl_we       = 1'b0;
        acc_c        = 1'b0;
        rej_c        = 1'b0;
        recv_c       = 1'b0;
        rect_c       = '0;
        if (take)
        begin
            case (cmd_t'(cmd))
                CMD_LOAD:
                begin
                    if (count_reg >= MAX_CNT)
                    begin
                        rej_c = 1'b1;
                    end
                    else
                    begin
                        tbl_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_CLEAR, CMD_RESET:
                begin
                    if (cmd_t'(cmd) == CMD_CLEAR)
                    begin
                        count_next = '0;
                    end
                    mode_next    = MODE_IDLE;
                    cause_next   = CAUSE_NONE;
                    cur_next     = '0;
                    records_next = '0;
                    step_t_next  = '0;
                    run_t_next   = '0;
                end
                CMD_START:
                begin
                    if (count_reg == '0 ||
                        (mode_reg != MODE_IDLE && mode_reg != MODE_DONE))
                    begin
                        rej_c = 1'b1;
                    end
                    else
                    begin
                        mode_next    = MODE_RUNNING;
                        cause_next   = CAUSE_NONE;
                        cur_next     = '0;
                        records_next = '0;
                        step_t_next  = '0;
                        run_t_next   = '0;
                    end
                end
                CMD_PAUSE:
                begin
                    if (mode_reg == MODE_RUNNING)
                    begin
                        mode_next = MODE_PAUSED;
                    end
                end
                CMD_RESUME:
                begin
                    if (mode_reg == MODE_PAUSED)
                    begin
                        mode_next = MODE_RUNNING;
                    end
                end
                CMD_ABORT:
                begin
                    mode_next  = MODE_FAULT;
                    cause_next = CAUSE_ABORT;
                end
                CMD_TICK:
                begin
                    if (mode_reg == MODE_RUNNING)
                    begin
                        if (past_end)
                        begin
                            mode_next = MODE_DONE;
                        end
                        else
                        begin
                            step_t_next = step_sat;
                            run_t_next  = run_sat;
                            if (step_sat > {8'd0, cur_row.limit_ms})
                            begin
                                mode_next  = MODE_FAULT;
                                cause_next = CAUSE_TIMEOUT;
                            end
                        end
                    end
                end
                CMD_COMPLETE:
                begin
                    if (mode_reg == MODE_RUNNING && !past_end)
                    begin
                        recv_c = 1'b1;
                        rect_c = step_t_reg;
                        if (records_reg < MAX_CNT)
                        begin
                            records_next = records_reg + CNT_W'(1);
                        end
                        if (!step_ok)
                        begin
                            mode_next  = MODE_FAULT;
                            cause_next = CAUSE_FAILED;
                        end
                        else
                        begin
                            cur_next    = cur_inc;
                            step_t_next = '0;
                            acc_c       = 1'b1;
                            if (cur_inc >= count_reg)
                            begin
                                mode_next = MODE_DONE;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            cause_reg     <= CAUSE_NONE;
            cur_reg       <= '0;
            count_reg     <= '0;
            records_reg   <= '0;
            step_t_reg    <= '0;
            run_t_reg     <= '0;
            fwd_hit_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            cause_reg     <= cause_next;
            cur_reg       <= cur_next;
            count_reg     <= count_next;
            records_reg   <= records_next;
            step_t_reg    <= step_t_next;
            run_t_reg     <= run_t_next;
            fwd_hit_reg   <= fwd_hit_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fwd_hit_next)
        begin
            fwd_row_reg <= tbl_wrow;
        end
        if (take)
        begin
            s1_acc_reg  <= acc_c;
            s1_rej_reg  <= rej_c;
            s1_recv_reg <= recv_c;
            s1_rect_reg <= rect_c;
        end
        // state registers still hold the post-command state of the transaction in s1
        if (s1_adv)
        begin
            o_state_reg  <= mode_code(mode_reg);
            o_step_reg   <= 5'(cur_reg);
            o_step_t_reg <= step_t_reg;
            o_run_t_reg  <= run_t_reg;
            o_cause_reg  <= cause_reg;
            o_acc_reg    <= s1_acc_reg;
            o_rej_reg    <= s1_rej_reg;
            o_fin_reg    <= 5'(records_reg);
            o_load_reg   <= 5'(count_reg);
            o_nom_reg    <= past_end ? 24'd0 : cur_row.nominal_ms;
            o_rect_reg   <= s1_rect_reg;
            o_recv_reg   <= s1_recv_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign run_state       = o_state_reg;
    assign step_number     = o_step_reg;
    assign step_time       = o_step_t_reg;
    assign run_time        = o_run_t_reg;
    assign fault_cause     = o_cause_reg;
    assign accepted        = o_acc_reg;
    assign rejected        = o_rej_reg;
    assign finished_count  = o_fin_reg;
    assign loaded_count    = o_load_reg;
    assign current_nominal = o_nom_reg;
    assign record_time     = o_rect_reg;
    assign record_valid    = o_recv_reg;

endmodule
